>>> rtl/core/xdsd_pkg.sv
// Shared types and constants of the XOR delta stream decoder.
`timescale 1ns / 1ps
`default_nettype none

package xdsd_pkg;

    localparam logic [7:0] OP_SHORT_RUN = 8'h00;
    localparam logic [7:0] OP_LONG      = 8'h80;
    localparam int         OP_SKIP_BIT  = 7;

    localparam int LEN_W = 15;

    localparam int LONG_SKIP_CLEAR_BIT = 15;
    localparam int LONG_RUN_BIT        = 14;
    localparam int LONG_COUNT_W        = 14;

    localparam logic [LEN_W-1:0] SHORT_ZERO_COUNT = 15'd256;
    localparam logic [LEN_W-1:0] LONG_ZERO_COUNT  = 15'h4000;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_SKIP,
        CMD_RUN,
        CMD_EOF
    } cmd_kind_t;

    typedef struct packed {
        logic             clear;
        cmd_kind_t        kind;
        logic [LEN_W-1:0] amount;
        logic [7:0]       value;
    } cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/xdsd_front.sv
// Opcode parser that turns delta bytes into position and XOR commands.
`timescale 1ns / 1ps
`default_nettype none

module xdsd_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         byte_accept,
    input  wire logic [7:0]   delta_byte,
    input  wire logic         frame_start,
    output logic              cmd_push,
    output xdsd_pkg::cmd_t    cmd
);
    import xdsd_pkg::*;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_SR_COUNT,
        PH_SR_VALUE,
        PH_LONG_LO,
        PH_LONG_HI,
        PH_LR_VALUE,
        PH_DUMP,
        PH_ENDED
    } phase_t;

    phase_t           phase_reg, phase_next, phase_eff;
    logic [LEN_W-1:0] remain_reg, remain_next, remain_eff;
    logic [7:0]       low_reg, low_next, low_eff;
    logic [15:0]      word;
    logic [LEN_W-1:0] long_count;
    logic [LEN_W-1:0] remain_dec;

    assign phase_eff  = frame_start ? PH_OPCODE : phase_reg;
    assign remain_eff = frame_start ? '0 : remain_reg;
    assign low_eff    = frame_start ? '0 : low_reg;
    assign word       = {delta_byte, low_eff};
    assign long_count = LEN_W'(word[LONG_COUNT_W-1:0]);
    assign remain_dec = remain_eff - LEN_W'(1);

    always_comb begin
        phase_next  = phase_eff;
        remain_next = remain_eff;
        low_next    = low_eff;
        cmd.clear   = frame_start;
        cmd.kind    = CMD_NONE;
        cmd.amount  = '0;
        cmd.value   = delta_byte;
        unique case (phase_eff)
            PH_OPCODE: begin
                if (delta_byte == OP_SHORT_RUN) begin
                    phase_next = PH_SR_COUNT;
                end else if (delta_byte == OP_LONG) begin
                    phase_next = PH_LONG_LO;
                end else if (delta_byte[OP_SKIP_BIT]) begin
                    cmd.kind   = CMD_SKIP;
                    cmd.amount = LEN_W'(delta_byte[6:0]);
                end else begin
                    remain_next = LEN_W'(delta_byte);
                    phase_next  = PH_DUMP;
                end
            end
            PH_SR_COUNT: begin
                remain_next = (delta_byte == 8'd0) ? SHORT_ZERO_COUNT : LEN_W'(delta_byte);
                phase_next  = PH_SR_VALUE;
            end
            PH_SR_VALUE, PH_LR_VALUE: begin
                cmd.kind    = CMD_RUN;
                cmd.amount  = remain_eff;
                remain_next = '0;
                phase_next  = PH_OPCODE;
            end
            PH_LONG_LO: begin
                low_next   = delta_byte;
                phase_next = PH_LONG_HI;
            end
            PH_LONG_HI: begin
                if (word == 16'd0) begin
                    cmd.kind   = CMD_EOF;
                    cmd.value  = '0;
                    phase_next = PH_ENDED;
                end else if (!word[LONG_SKIP_CLEAR_BIT]) begin
                    cmd.kind   = CMD_SKIP;
                    cmd.amount = word[LEN_W-1:0];
                    phase_next = PH_OPCODE;
                end else begin
                    remain_next = (long_count == '0) ? LONG_ZERO_COUNT : long_count;
                    phase_next  = word[LONG_RUN_BIT] ? PH_LR_VALUE : PH_DUMP;
                end
            end
            PH_DUMP: begin
                cmd.kind    = CMD_RUN;
                cmd.amount  = LEN_W'(1);
                remain_next = remain_dec;
                if (remain_dec == '0) begin
                    phase_next = PH_OPCODE;
                end
            end
            PH_ENDED: begin
                phase_next = PH_ENDED;
            end
            default: begin
                phase_next = PH_OPCODE;
            end
        endcase
    end

    assign cmd_push = byte_accept && (frame_start || (cmd.kind != CMD_NONE));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_OPCODE;
            remain_reg <= '0;
            low_reg    <= '0;
        end else if (byte_accept) begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
            low_reg    <= low_next;
        end
    end

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_push && (cmd.kind == CMD_RUN) |-> cmd.amount != '0)
        else $error("run command with zero length");

endmodule

`default_nettype wire

>>> rtl/core/xdsd_cmd_fifo.sv
// Two-entry command queue between the parser and the position unit.
`timescale 1ns / 1ps
`default_nettype none

module xdsd_cmd_fifo (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire xdsd_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output xdsd_pkg::cmd_t      head_cmd,
    output logic                empty,
    output logic                full
);
    import xdsd_pkg::*;

    localparam int DEPTH   = 2;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    cmd_t               mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == COUNT_W'(DEPTH));
    assign head_cmd = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + COUNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("command queue popped while empty");

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("command queue pushed while full");

endmodule

`default_nettype wire

>>> rtl/core/xdsd_back.sv
// Position tracker that executes queued commands and holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module xdsd_back #(
    parameter int POS_BITS = 16
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cmd_avail,
    input  wire xdsd_pkg::cmd_t cmd,
    output logic                cmd_pop,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [15:0]         m_write_pos,
    output logic [14:0]         m_write_len,
    output logic [7:0]          m_xor_value,
    output logic                m_end_of_frame
);
    import xdsd_pkg::*;

    localparam int SUM_W = (POS_BITS > LEN_W) ? POS_BITS : LEN_W;
    localparam int OUT_W = (POS_BITS > 16) ? POS_BITS : 16;

    logic [POS_BITS-1:0] pos_reg, pos_next, pos_base;
    logic [SUM_W-1:0]    pos_sum;
    logic [OUT_W-1:0]    pos_wide;
    logic                valid_reg;
    logic                emits;
    logic [15:0]         wpos_reg;
    logic [14:0]         wlen_reg;
    logic [7:0]          xval_reg;
    logic                eof_reg;

    assign cmd_pop  = cmd_avail && (!valid_reg || m_ready);
    assign pos_base = cmd.clear ? '0 : pos_reg;
    assign pos_sum  = SUM_W'(pos_base) + SUM_W'(cmd.amount);
    assign pos_wide = OUT_W'(pos_base);
    assign emits    = (cmd.kind == CMD_RUN) || (cmd.kind == CMD_EOF);

    always_comb begin
        unique case (cmd.kind)
            CMD_SKIP, CMD_RUN: pos_next = pos_sum[POS_BITS-1:0];
            default:           pos_next = pos_base;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd_pop) begin
                pos_reg   <= pos_next;
                valid_reg <= emits;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd_pop && emits) begin
            wpos_reg <= pos_wide[15:0];
            wlen_reg <= (cmd.kind == CMD_EOF) ? '0 : cmd.amount;
            xval_reg <= (cmd.kind == CMD_EOF) ? '0 : cmd.value;
            eof_reg  <= (cmd.kind == CMD_EOF);
        end
    end

    assign m_valid        = valid_reg;
    assign m_write_pos    = wpos_reg;
    assign m_write_len    = wlen_reg;
    assign m_xor_value    = xval_reg;
    assign m_end_of_frame = eof_reg;

    a_eof_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_end_of_frame |-> (m_write_len == '0) && (m_xor_value == '0))
        else $error("end-of-frame result carries a run");

endmodule

`default_nettype wire

>>> rtl/core/xor_delta_stream_decoder_unit.sv
// Top level of the XOR delta stream decoder: parser, command queue and position unit.
`timescale 1ns / 1ps
`default_nettype none

//  Channel | Direction | Handshake          | Payload
//  s_      | in        | s_valid / s_ready  | s_delta_byte, s_frame_start
//  m_      | out       | m_valid / m_ready  | m_write_pos, m_write_len, m_xor_value,
//          |           |                    | m_end_of_frame
//
//  One delta byte is taken per cycle while s_ready is high; the parser state is registered.
//  A result reaches the output through the command queue, then the result register.
//  Reset is synchronous on aresetn; no clearing pass, the block is ready right after reset.
//  s_ready falls only when the two-entry command queue is full, which happens only while
//  the result register is held by a low m_ready.

module xor_delta_stream_decoder_unit #(
    parameter int POS_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_delta_byte,
    input  wire logic        s_frame_start,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_write_pos,
    output logic [14:0]      m_write_len,
    output logic [7:0]       m_xor_value,
    output logic             m_end_of_frame
);
    import xdsd_pkg::*;

    // The front end classifies each transfer into at most one command. A frame start
    // always produces a command so the position unit can clear its position in order.
    logic byte_accept;
    logic cmd_push;
    cmd_t push_cmd;
    cmd_t head_cmd;
    logic q_empty;
    logic q_full;
    logic cmd_pop;

    assign s_ready     = !q_full;
    assign byte_accept = s_valid && s_ready;

    xdsd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .delta_byte  (s_delta_byte),
        .frame_start (s_frame_start),
        .cmd_push    (cmd_push),
        .cmd         (push_cmd)
    );

    // The queue decouples the parser from the result side, so a stalled output
    // transfer does not stop byte intake until both entries are in use.
    xdsd_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .pop      (cmd_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // The back end owns the destination position: skips only move it, runs and dump
    // bytes report it and then move it, and the end of frame reports it unchanged.
    xdsd_back #(
        .POS_BITS (POS_BITS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_avail      (!q_empty),
        .cmd            (head_cmd),
        .cmd_pop        (cmd_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_write_pos    (m_write_pos),
        .m_write_len    (m_write_len),
        .m_xor_value    (m_xor_value),
        .m_end_of_frame (m_end_of_frame)
    );

endmodule

`default_nettype wire

>>> bench/testbench.sv
// Self-checking testbench for the XOR delta stream decoder, with directed and random streams.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

    import xdsd_pkg::*;

    // The decoder is built with its default position width.
    localparam int POS_BITS = 16;

    // Random part length, counted in bytes that the parser actually consumes.
    localparam int RANDOM_ITEMS = 400;

    // Parser phases of the local decoder copy.
    typedef enum logic [2:0] {
        DP_OPCODE,
        DP_RUN_COUNT,
        DP_RUN_VALUE,
        DP_LONG_LO,
        DP_LONG_HI,
        DP_LONG_RUN_VALUE,
        DP_DUMP,
        DP_ENDED
    } parse_state_e;

    // One XOR command as it leaves the decoder.
    typedef struct packed {
        logic [15:0]      pos;
        logic [LEN_W-1:0] len;
        logic [7:0]       val;
        logic             eof;
    } xor_cmd_t;

    // One row of the directed stream. A pinned row carries its result typed in by hand.
    typedef struct packed {
        logic [7:0] delta;
        logic       fs;
        logic       pinned;
        xor_cmd_t   want;
    } stim_row_t;

    localparam xor_cmd_t NO_CMD = '0;
    localparam int DIRECTED_ROWS = 25;

    // Directed stream: short run with the zero-count repair, a short dump, both skip forms,
    // a long skip, a long run and a long dump with the zero-count repair, a frame start in
    // the middle of that dump, the end of frame, an ignored byte after it and a restart.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{8'h00, 1'b1, 1'b0, NO_CMD},
        '{8'h00, 1'b0, 1'b0, NO_CMD},
        '{8'hFF, 1'b0, 1'b1, '{16'd0, 15'd256, 8'hFF, 1'b0}},
        '{8'h02, 1'b0, 1'b0, NO_CMD},
        '{8'hA5, 1'b0, 1'b1, '{16'd256, 15'd1, 8'hA5, 1'b0}},
        '{8'h5A, 1'b0, 1'b1, '{16'd257, 15'd1, 8'h5A, 1'b0}},
        '{8'hFF, 1'b0, 1'b0, NO_CMD},
        '{8'h81, 1'b0, 1'b0, NO_CMD},
        '{8'h80, 1'b0, 1'b0, NO_CMD},
        '{8'hFF, 1'b0, 1'b0, NO_CMD},
        '{8'h7F, 1'b0, 1'b0, NO_CMD},
        '{8'h80, 1'b0, 1'b0, NO_CMD},
        '{8'h00, 1'b0, 1'b0, NO_CMD},
        '{8'hC0, 1'b0, 1'b0, NO_CMD},
        '{8'h3C, 1'b0, 1'b0, NO_CMD},
        '{8'h80, 1'b0, 1'b0, NO_CMD},
        '{8'h00, 1'b0, 1'b0, NO_CMD},
        '{8'h80, 1'b0, 1'b0, NO_CMD},
        '{8'h11, 1'b0, 1'b0, NO_CMD},
        '{8'hEE, 1'b0, 1'b0, NO_CMD},
        '{8'h80, 1'b1, 1'b0, NO_CMD},
        '{8'h00, 1'b0, 1'b0, NO_CMD},
        '{8'h00, 1'b0, 1'b1, '{16'd0, 15'd0, 8'h00, 1'b1}},
        '{8'h00, 1'b0, 1'b0, NO_CMD},
        '{8'h03, 1'b1, 1'b0, NO_CMD}
    };

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_delta_byte = 8'h00;
    logic             s_frame_start = 1'b0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [15:0]      m_write_pos;
    logic [14:0]      m_write_len;
    logic [7:0]       m_xor_value;
    logic             m_end_of_frame;

    // Local decoder state, kept in step with every accepted input transfer.
    parse_state_e          dec_state = DP_OPCODE;
    logic [POS_BITS-1:0]   dec_pos = '0;
    logic [LEN_W-1:0]      dec_left = '0;
    logic [7:0]            dec_low = '0;

    // Commands that the decoder still owes, oldest first.
    xor_cmd_t pending_cmds[$];
    xor_cmd_t head_cmd;

    int  error_count = 0;
    int  live_items = 0;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;
    bit  pending_fs = 1'b0;
    int  rx_stall_left = 0;

    xor_delta_stream_decoder_unit #(
        .POS_BITS(POS_BITS)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_delta_byte  (s_delta_byte),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_write_pos   (m_write_pos),
        .m_write_len   (m_write_len),
        .m_xor_value   (m_xor_value),
        .m_end_of_frame(m_end_of_frame)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Safety net: far beyond the slowest legal run, even with every stall at its longest.
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Advances the local decoder by one byte and tells whether a command comes out.
    task automatic decode_delta_byte(input logic [7:0] b, input logic fs,
                                     output bit produced, output xor_cmd_t cmd);
        logic [15:0] word;
        begin
            produced = 1'b0;
            cmd = NO_CMD;
            if (fs) begin
                dec_state = DP_OPCODE;
                dec_pos = '0;
                dec_left = '0;
                dec_low = '0;
            end
            word = {b, dec_low};
            case (dec_state)
                DP_OPCODE: begin
                    if (b == OP_SHORT_RUN) begin
                        dec_state = DP_RUN_COUNT;
                    end else if (b == OP_LONG) begin
                        dec_state = DP_LONG_LO;
                    end else if (b[OP_SKIP_BIT]) begin
                        dec_pos = dec_pos + b[6:0];
                    end else begin
                        dec_left = LEN_W'(b);
                        dec_state = DP_DUMP;
                    end
                end
                DP_RUN_COUNT: begin
                    dec_left = (b == 8'h00) ? SHORT_ZERO_COUNT : LEN_W'(b);
                    dec_state = DP_RUN_VALUE;
                end
                DP_RUN_VALUE, DP_LONG_RUN_VALUE: begin
                    cmd = '{dec_pos[15:0], dec_left, b, 1'b0};
                    produced = 1'b1;
                    dec_pos = dec_pos + dec_left;
                    dec_left = '0;
                    dec_state = DP_OPCODE;
                end
                DP_LONG_LO: begin
                    dec_low = b;
                    dec_state = DP_LONG_HI;
                end
                DP_LONG_HI: begin
                    if (word == 16'h0000) begin
                        cmd = '{dec_pos[15:0], 15'd0, 8'h00, 1'b1};
                        produced = 1'b1;
                        dec_state = DP_ENDED;
                    end else if (!word[LONG_SKIP_CLEAR_BIT]) begin
                        dec_pos = dec_pos + word[14:0];
                        dec_state = DP_OPCODE;
                    end else begin
                        dec_left = (word[LONG_COUNT_W-1:0] == '0) ? LONG_ZERO_COUNT
                                                                  : LEN_W'(word[LONG_COUNT_W-1:0]);
                        dec_state = word[LONG_RUN_BIT] ? DP_LONG_RUN_VALUE : DP_DUMP;
                    end
                end
                DP_DUMP: begin
                    cmd = '{dec_pos[15:0], 15'd1, b, 1'b0};
                    produced = 1'b1;
                    dec_pos = dec_pos + 1'b1;
                    dec_left = dec_left - 1'b1;
                    if (dec_left == '0) begin
                        dec_state = DP_OPCODE;
                    end
                end
                default: begin
                    // After the end of frame every byte is dropped until a frame start.
                end
            endcase
        end
    endtask

    // Offers one byte, after a random gap while tx_idle is set, and, once the transfer happens, records
    // what the decoder has to answer. Valid is raised at the falling edge and the
    // handshake is judged at the rising edge.
    task automatic push_byte(input logic [7:0] b, input logic fs, input logic pinned,
                             input xor_cmd_t want);
        int       gap;
        bit       produced;
        xor_cmd_t cmd;
        begin
            gap = tx_idle ? $urandom_range(0, 13) : 0;
            @(negedge aclk);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_valid <= 1'b1;
            s_delta_byte <= b;
            s_frame_start <= fs;
            do @(posedge aclk); while (!s_ready);
            if (fs || dec_state != DP_ENDED) begin
                live_items++;
            end
            decode_delta_byte(b, fs, produced, cmd);
            if (produced) begin
                pending_cmds.push_back(pinned ? want : cmd);
            end
        end
    endtask

    // Random-stream byte. A frame start is either requested or, now and then, thrown in.
    task automatic put(input logic [7:0] b);
        logic fs;
        begin
            fs = pending_fs || ($urandom_range(0, 59) == 0);
            pending_fs = 1'b0;
            push_byte(b, fs, 1'b0, NO_CMD);
        end
    endtask

    // Holds the sender off until every owed command has been transferred.
    task automatic drain_results();
        begin
            @(negedge aclk);
            s_valid <= 1'b0;
            while (pending_cmds.size() != 0) @(posedge aclk);
        end
    endtask

    // Emits one well-formed command with random content, or noise, or a broken command, or only requests a frame start.
    task automatic send_command();
        int          pick;
        int          n;
        logic [13:0] cnt;
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                put(OP_SHORT_RUN);
                put(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom));
                put(8'($urandom));
            end else if (pick < 35) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 6);
                put(8'(n));
                repeat (n) put(8'($urandom));
            end else if (pick < 50) begin
                put(8'h80 | 8'($urandom_range(1, 127)));
            end else if (pick < 60) begin
                put(OP_LONG);
                put(8'($urandom));
                put({1'b0, 7'($urandom)});
            end else if (pick < 70) begin
                cnt = ($urandom_range(0, 7) == 0) ? 14'($urandom) : 14'($urandom_range(0, 40));
                put(OP_LONG);
                put(cnt[7:0]);
                put({2'b11, cnt[13:8]});
                put(8'($urandom));
            end else if (pick < 80) begin
                cnt = 14'($urandom_range(1, 6));
                put(OP_LONG);
                put(cnt[7:0]);
                put({2'b10, cnt[13:8]});
                repeat (int'(cnt)) put(8'($urandom));
            end else if (pick < 85) begin
                // End of frame, then a few bytes the parser must ignore, then a restart.
                put(OP_LONG);
                put(8'h00);
                put(8'h00);
                repeat ($urandom_range(0, 3)) put(8'($urandom));
                pending_fs = 1'b1;
            end else if (pick < 90) begin
                pending_fs = ($urandom_range(0, 1) == 1);
                put(8'($urandom));
            end else if (pick < 95) begin
                // A command cut short by a frame start.
                case ($urandom_range(0, 2))
                    0: put(OP_SHORT_RUN);
                    1: begin
                        put(OP_LONG);
                        put(8'($urandom));
                    end
                    default: begin
                        put(8'($urandom_range(2, 127)));
                        put(8'($urandom));
                    end
                endcase
                pending_fs = 1'b1;
            end else begin
                pending_fs = 1'b1;
            end
        end
    endtask

    // Result side: m_ready stays low while the drawn stall lasts, then high until
    // the next transfer.
    always @(negedge aclk) begin
        if (rx_stall_left > 0) begin
            m_ready <= 1'b0;
            rx_stall_left--;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Every result transfer is held against the oldest owed command.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_cmds.size() == 0) begin
                $error("result with nothing owed: write_pos %0d write_len %0d",
                       m_write_pos, m_write_len);
                error_count++;
            end else begin
                head_cmd = pending_cmds.pop_front();
                compare_field("write_pos", head_cmd.pos, m_write_pos);
                compare_field("write_len", head_cmd.len, m_write_len);
                compare_field("xor_value", head_cmd.val, m_xor_value);
                compare_field("end_of_frame", head_cmd.eof, m_end_of_frame);
            end
            rx_stall_left = rx_idle ? $urandom_range(0, 13) : 0;
        end
    end

    initial begin : stimulus
        int  row;
        int  cmd_index;
        cmd_index = 0;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed stream. Rows without a hand-typed result are judged by the local decoder.
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            push_byte(directed_rows[row].delta, directed_rows[row].fs,
                      directed_rows[row].pinned, directed_rows[row].want);
        end
        drain_results();

        live_items = 0;
        while (live_items < RANDOM_ITEMS) begin
            // Every 40 commands a new idling mix, sometimes with one side or both at full rate.
            if (cmd_index % 40 == 0) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 49) == 0) begin
                drain_results();
            end
            send_command();
            cmd_index++;
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> xor_delta_stream_decoder_unit.f
rtl/core/xdsd_pkg.sv
rtl/core/xdsd_front.sv
rtl/core/xdsd_cmd_fifo.sv
rtl/core/xdsd_back.sv
rtl/core/xor_delta_stream_decoder_unit.sv
bench/testbench.sv
